>>> rtl/buddy_page_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared property forms for the allocator core checks.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPA_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("buddy allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BPA_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("buddy allocator check failed");

`endif

>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, sentinel and status codes of the allocator core.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int POOL_PAGES  = 4096;
	localparam int ORDER_COUNT = 11;
	localparam int IDX_W       = $clog2(POOL_PAGES);
	localparam int LINK_W      = IDX_W + 1;
	localparam int ORD_W       = 4;
	localparam int OIDX_W      = $clog2(ORDER_COUNT);

	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_PAGES);
	localparam logic [ORD_W-1:0]  ORD_MAX   = ORD_W'(ORDER_COUNT - 1);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOT_USED = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic REG_LOW = 1'b0;
	localparam logic REG_END = 1'b1;

	// page info entry: used tag over order
	typedef struct packed {
		logic             used;
		logic [ORD_W-1:0] order;
	} page_info_t;

endpackage

>>> rtl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Allocates and frees power-of-two page blocks from free lists kept in
// on-chip memories, with buddy split on allocate and merge on free.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                    | handshake
//  ---------+--------------------------------------------+---------------------
//  command  | action, block_order, page_index            | start & !busy
//  result   | status, granted_index                      | done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata    | APB, pready high
//
//  Cycles, counted in clock edges from the accepting edge to the edge that
//  raises done: an allocate takes 4 plus 1 per split level, at most 14 (the
//  lower lists are empty when a split runs); a failed scan takes 1. A free
//  takes 4, 5 when its list is not empty, plus 2 per merge level and 1 for a
//  buddy that fails the merge check, at most 25; a free of a page not in use
//  takes 2. The read-modify-write loop over the page info and link memories
//  sets these figures. Out-of-range frees and oversized orders raise done
//  right after the accepting edge.
//  Reset: after arst_n rises, a clearing pass of POOL_PAGES (4096) cycles
//  marks every page used at order 0; busy stays high through it.
//  The result side cannot stall; done marks each result for one cycle.
//
`include "buddy_page_allocator_core_macros.svh"

module buddy_page_allocator_core import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// command transaction
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [3:0]        block_order,
	input  logic [IDX_W-1:0]  page_index,
	// result transaction
	output logic              done,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  granted_index,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] A_SCAN  = 4'd2;
	localparam logic [3:0] A_RD    = 4'd3;
	localparam logic [3:0] A_UNL   = 4'd4;
	localparam logic [3:0] A_SPL   = 4'd5;
	localparam logic [3:0] A_SPL2  = 4'd6;
	localparam logic [3:0] F_RD    = 4'd7;
	localparam logic [3:0] F_CHK   = 4'd8;
	localparam logic [3:0] F_BUD   = 4'd9;
	localparam logic [3:0] F_MRG   = 4'd10;
	localparam logic [3:0] F_PUSH  = 4'd11;
	localparam logic [3:0] F_PUSH2 = 4'd12;

	// Memories: page info, forward and backward links
	page_info_t        info_mem [POOL_PAGES];
	logic [LINK_W-1:0] next_mem [POOL_PAGES];
	logic [LINK_W-1:0] prev_mem [POOL_PAGES];

	// Free list heads, one per order
	logic [LINK_W-1:0] head_q [ORDER_COUNT];

	logic [3:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  blk_q;
	logic [IDX_W-1:0]  bud_q;
	logic [LINK_W-1:0] h_q;
	logic [ORD_W-1:0]  o_q;
	logic [ORD_W-1:0]  ord_q;
	logic [IDX_W-1:0]  low_q;
	logic [LINK_W-1:0] end_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  granted_q;

	// Registered read data
	page_info_t        info_rd;
	logic [LINK_W-1:0] next_rd;
	logic [LINK_W-1:0] prev_rd;

	// Write controls
	logic              info_we, next_we, prev_we, head_we;
	logic [IDX_W-1:0]  info_wa, next_wa, prev_wa;
	page_info_t        info_wd;
	logic [LINK_W-1:0] next_wd, prev_wd, head_wd;
	logic [OIDX_W-1:0] head_wa;
	logic [IDX_W-1:0]  raddr;

	logic [LINK_W-1:0] end_eff;
	logic              accept, cfg_wr;
	logic              idx_out;
	logic              scan_hit;
	logic [ORD_W-1:0]  scan_ord;
	logic [ORD_W-1:0]  o_dn;
	logic [LINK_W-1:0] bud_a;
	logic [IDX_W-1:0]  bud_f;
	logic              bud_f_in;
	logic              merge_ok;
	logic [IDX_W-1:0]  merge_blk;
	logic [ORD_W-1:0]  chk_ord;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	assign done          = done_q;
	assign status        = status_q;
	assign granted_index = granted_q;

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_END) begin
			prdata = 32'(end_q);
		end else begin
			prdata = 32'(low_q);
		end
	end

	// Clip the pool end to the store size
	assign end_eff = (end_q > NONE_LINK) ? NONE_LINK : end_q;
	assign idx_out = ({1'b0, page_index} < {1'b0, low_q}) ||
		({1'b0, page_index} >= end_eff);

	// Lowest non-empty list at or above the requested order
	always_comb begin
		scan_hit = 1'b0;
		scan_ord = '0;
		for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
			if ((ORD_W'(i) >= ord_q) && (head_q[i] < NONE_LINK)) begin
				scan_hit = 1'b1;
				scan_ord = ORD_W'(i);
			end
		end
	end

	// Split: upper half one order down
	assign o_dn  = o_q - ORD_W'(1);
	assign bud_a = {1'b0, blk_q} + (LINK_W'(1) << o_dn);

	// Merge: buddy at current order and its pool check
	assign bud_f    = blk_q ^ (IDX_W'(1) << o_q);
	assign bud_f_in = ({1'b0, bud_f} >= {1'b0, low_q}) && ({1'b0, bud_f} < end_eff);
	assign merge_ok = !info_rd.used && (info_rd.order == o_q);
	assign merge_blk = (bud_q < blk_q) ? bud_q : blk_q;
	assign chk_ord  = (info_rd.order > ORD_MAX) ? ORD_MAX : info_rd.order;

	assign raddr = (state_q == F_BUD) ? bud_f : blk_q;

	// Memory and head write decode
	always_comb begin
		info_we = 1'b0; info_wa = blk_q; info_wd = '{used: 1'b0, order: o_q};
		next_we = 1'b0; next_wa = blk_q; next_wd = NONE_LINK;
		prev_we = 1'b0; prev_wa = blk_q; prev_wd = NONE_LINK;
		head_we = 1'b0; head_wa = OIDX_W'(o_q); head_wd = NONE_LINK;
		unique case (state_q) inside
			S_CLR: begin
				info_we = 1'b1;
				info_wa = clr_q;
				info_wd = '{used: 1'b1, order: '0};
			end
			A_UNL, F_MRG: begin
				if (state_q == A_UNL || merge_ok) begin
					if (prev_rd < NONE_LINK) begin
						next_we = 1'b1;
						next_wa = prev_rd[IDX_W-1:0];
						next_wd = next_rd;
					end else begin
						head_we = 1'b1;
						head_wd = next_rd;
					end
					if (next_rd < NONE_LINK) begin
						prev_we = 1'b1;
						prev_wa = next_rd[IDX_W-1:0];
						prev_wd = prev_rd;
					end
					if (state_q == F_MRG) begin
						info_we = 1'b1;
						info_wa = merge_blk;
						info_wd = '{used: 1'b0, order: o_q + ORD_W'(1)};
					end
				end
			end
			A_SPL: begin
				if (o_q == ord_q) begin
					info_we = 1'b1;
					info_wd = '{used: 1'b1, order: ord_q};
				end else if (bud_a < NONE_LINK) begin
					info_we = 1'b1;
					info_wa = bud_a[IDX_W-1:0];
					info_wd = '{used: 1'b0, order: o_dn};
					next_we = 1'b1;
					next_wa = bud_a[IDX_W-1:0];
					next_wd = head_q[o_dn];
					prev_we = 1'b1;
					prev_wa = bud_a[IDX_W-1:0];
					head_we = 1'b1;
					head_wa = OIDX_W'(o_dn);
					head_wd = bud_a;
				end
			end
			A_SPL2: begin
				prev_we = 1'b1;
				prev_wa = h_q[IDX_W-1:0];
				prev_wd = {1'b0, bud_q};
			end
			F_CHK: begin
				if (info_rd.used) begin
					info_we = 1'b1;
					info_wd = '{used: 1'b0, order: chk_ord};
				end
			end
			F_PUSH: begin
				next_we = 1'b1;
				next_wd = head_q[o_q];
				prev_we = 1'b1;
				head_we = 1'b1;
				head_wd = {1'b0, blk_q};
			end
			F_PUSH2: begin
				prev_we = 1'b1;
				prev_wa = h_q[IDX_W-1:0];
				prev_wd = {1'b0, blk_q};
			end
			default: begin
			end
		endcase
	end

	// Memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_wa] <= info_wd;
		end
		info_rd <= info_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd <= next_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd <= prev_mem[raddr];
	end

	// Configuration registers and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			end_q <= NONE_LINK;
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_q[i] <= NONE_LINK;
			end
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_END) begin
					end_q <= pwdata[LINK_W-1:0];
				end else begin
					low_q <= pwdata[IDX_W-1:0];
				end
			end
			if (head_we) begin
				head_q[head_wa] <= head_wd;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			granted_q <= '0;
			blk_q     <= '0;
			bud_q     <= '0;
			h_q       <= NONE_LINK;
			o_q       <= '0;
			ord_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					// Sweep page info to used, order 0
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ord_q <= block_order;
						blk_q <= page_index;
						if (action == ACT_ALLOC) begin
							if (block_order > ORD_MAX) begin
								// Answer out of memory at once
								done_q    <= 1'b1;
								status_q  <= ST_NOMEM;
								granted_q <= '0;
							end else begin
								state_q <= A_SCAN;
							end
						end else if (idx_out) begin
							done_q    <= 1'b1;
							status_q  <= ST_RANGE;
							granted_q <= '0;
						end else begin
							state_q <= F_RD;
						end
					end
				end
				A_SCAN: begin
					if (scan_hit) begin
						o_q     <= scan_ord;
						blk_q   <= head_q[scan_ord][IDX_W-1:0];
						state_q <= A_RD;
					end else begin
						done_q    <= 1'b1;
						status_q  <= ST_NOMEM;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				A_RD: begin
					// Fetch links of the head block
					state_q <= A_UNL;
				end
				A_UNL: begin
					state_q <= A_SPL;
				end
				A_SPL: begin
					if (o_q == ord_q) begin
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						granted_q <= blk_q;
						state_q   <= S_IDLE;
					end else begin
						o_q   <= o_dn;
						bud_q <= bud_a[IDX_W-1:0];
						h_q   <= head_q[o_dn];
						if (bud_a < NONE_LINK && head_q[o_dn] < NONE_LINK) begin
							state_q <= A_SPL2;
						end
					end
				end
				A_SPL2: begin
					state_q <= A_SPL;
				end
				F_RD: begin
					state_q <= F_CHK;
				end
				F_CHK: begin
					if (!info_rd.used) begin
						done_q    <= 1'b1;
						status_q  <= ST_NOT_USED;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						o_q     <= chk_ord;
						state_q <= F_BUD;
					end
				end
				F_BUD: begin
					bud_q <= bud_f;
					if (o_q < ORD_MAX && bud_f_in) begin
						state_q <= F_MRG;
					end else begin
						state_q <= F_PUSH;
					end
				end
				F_MRG: begin
					if (merge_ok) begin
						blk_q   <= merge_blk;
						o_q     <= o_q + ORD_W'(1);
						state_q <= F_BUD;
					end else begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					h_q <= head_q[o_q];
					if (head_q[o_q] < NONE_LINK) begin
						state_q <= F_PUSH2;
					end else begin
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				F_PUSH2: begin
					done_q    <= 1'b1;
					status_q  <= ST_OK;
					granted_q <= '0;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BPA_ASSERT_NOW(a_done_idle, done_q, !busy)
	`BPA_ASSERT_NOW(a_clr_no_done, state_q == S_CLR, !done_q)
	`BPA_ASSERT_NOW(a_fail_no_grant, done_q && (status_q != ST_OK), granted_q == '0)
	`BPA_ASSERT_NXT(a_scan_leaves, state_q == A_SCAN, (state_q == A_RD) || done_q)

endmodule
